// ----- sv/isoenc_pkg.sv -----
`default_nettype none

package isoenc_pkg;

  // escape sequence bytes
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] SB94_MARK  = 8'h28;
  localparam logic [7:0] MB_MARK    = 8'h24;
  localparam logic [7:0] SB96_MARK  = 8'h2D;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] HIGH_BIT   = 8'h80;

  // designation codes: designated flag, multi byte flag, final byte
  localparam logic [8:0] SET_NONE   = 9'h000;
  localparam logic [8:0] ASCII_SET  = 9'h142;
  localparam logic [8:0] LATIN1_SET = 9'h141;

  // request functions
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_REINIT = 1'b1;

  // most bytes one character can produce
  localparam int MAX_BYTES = 8;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one queued character: packed bytes (first byte lowest) and byte count
  typedef struct packed {
    logic [MAX_BYTES*8-1:0] data;
    logic [3:0]             count;
  } isoenc_entry_t;

  // queue write or read side
  typedef struct packed {
    logic          valid;
    isoenc_entry_t entry;
  } isoenc_q_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } isoenc_qstat_t;

endpackage

`default_nettype wire

// ----- sv/isoenc_in_if.sv -----
`default_nettype none

interface isoenc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] set_class;
  logic [6:0] final_byte;
  logic [2:0] char_len;
  logic [7:0] code_byte0;
  logic [7:0] code_byte1;
  logic [7:0] code_byte2;
  logic [7:0] code_byte3;

  modport source (
    output valid, func, set_class, final_byte, char_len,
           code_byte0, code_byte1, code_byte2, code_byte3,
    input  ready
  );

  modport sink (
    input  valid, func, set_class, final_byte, char_len,
           code_byte0, code_byte1, code_byte2, code_byte3,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/isoenc_out_if.sv -----
`default_nettype none

interface isoenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (
    output valid, out_byte, last,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/iso2022_escape_encoder.sv -----
// ISO 2022 escape encoder.
// in_ch takes one decoded character per request: set class, final byte and
// up to four code bytes, or a reinitialize request (func = 1) that reloads
// both designations from start_mode. out_ch gives the encoded byte stream,
// one byte per request, with last set on the final byte of each character.
// cfg_we/cfg_data write start_mode; it takes effect at the next reinitialize.
// The front classifies a character in the cycle it is accepted and updates
// the designations; a small queue then feeds the back, which shifts the
// bytes out through a registered output stage.
// When the queue and back are idle, the first byte of a character passes
// through a queue entry, the back's shift register and the output register.
// Throughput: one output byte per cycle while the receiver is ready; a
// character produces 1 to 8 bytes and a reinitialize produces none.
// in_ch.ready drops only while the queue is full.
// When the receiver stalls, the output byte holds and the back stops; the
// front keeps accepting until the queue fills.
// Reset clears start_mode, both designations, the queue and the output.
`default_nettype none

module iso2022_escape_encoder #(
  parameter int QueueDepth = isoenc_pkg::QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic     cfg_data,
  isoenc_in_if.sink     in_ch,
  isoenc_out_if.source  out_ch
);
  import isoenc_pkg::*;

  isoenc_q_t     push;
  isoenc_q_t     head;
  isoenc_qstat_t qstat;
  logic          pop;

  // classify and track designations
  isoenc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .qstat    (qstat),
    .push     (push)
  );

  // decoupling queue
  isoenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // byte serializer
  isoenc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // never push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !qstat.full)
    else $error("push into full queue");

  // queued characters carry one to eight bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (head.entry.count != 4'd0 && head.entry.count <= 4'd8))
    else $error("bad queued byte count");

  // every accepted encode request is queued, reinitialize is not
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (push.valid == (in_ch.func == FUNC_ENCODE)))
    else $error("request push mismatch");

  // output is empty after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
endmodule

`default_nettype wire

// ----- sv/isoenc_front.sv -----
`default_nettype none

module isoenc_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_data,
  isoenc_in_if.sink                   in_ch,
  input  wire isoenc_pkg::isoenc_qstat_t qstat,
  output isoenc_pkg::isoenc_q_t       push
);
  import isoenc_pkg::*;

  logic       start_mode_r;
  logic [8:0] left_set_r,  left_set_nxt;
  logic [8:0] right_set_r, right_set_nxt;

  logic       accept;
  logic       unsupported;
  logic       multi;
  logic       right;
  logic [8:0] set_id;
  logic [8:0] cur_set;
  logic       need_esc;
  logic [7:0] mark;
  logic [2:0] plen;
  logic [2:0] clen;
  logic [7:0] pre [4];
  logic [7:0] dat [4];
  logic [MAX_BYTES*8-1:0] packed_bytes;

  // accept whenever the queue has room
  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the character against its half's designation
  assign unsupported = in_ch.set_class[2];
  assign multi       = in_ch.set_class[0];
  assign right       = in_ch.set_class[1];
  assign set_id      = {1'b1, multi, in_ch.final_byte};
  assign cur_set     = right ? right_set_r : left_set_r;
  assign need_esc    = set_id != cur_set;
  assign mark        = right ? SB96_MARK : SB94_MARK;

  // escape prefix
  always_comb begin
    pre[0] = ESC_BYTE;
    if (multi) begin
      pre[1] = MB_MARK;
      pre[2] = mark;
      pre[3] = {1'b0, in_ch.final_byte};
      plen   = need_esc ? 3'd4 : 3'd0;
    end else begin
      pre[1] = mark;
      pre[2] = {1'b0, in_ch.final_byte};
      pre[3] = 8'h00;
      plen   = need_esc ? 3'd3 : 3'd0;
    end
  end

  // code bytes, high bit forced for the right half
  always_comb begin
    dat[0] = right ? (in_ch.code_byte0 | HIGH_BIT) : in_ch.code_byte0;
    dat[1] = right ? (in_ch.code_byte1 | HIGH_BIT) : in_ch.code_byte1;
    dat[2] = right ? (in_ch.code_byte2 | HIGH_BIT) : in_ch.code_byte2;
    dat[3] = right ? (in_ch.code_byte3 | HIGH_BIT) : in_ch.code_byte3;
  end

  // clamp length to one through four
  always_comb begin
    if (in_ch.char_len == 3'd0) begin
      clen = 3'd1;
    end else if (in_ch.char_len > 3'd4) begin
      clen = 3'd4;
    end else begin
      clen = in_ch.char_len;
    end
  end

  // pack prefix and code bytes into output order
  always_comb begin
    logic [3:0] rel;
    rel = 4'd0;
    packed_bytes = '0;
    for (int k = 0; k < MAX_BYTES; k++) begin
      rel = 4'(k) - {1'b0, plen};
      if (4'(k) < {1'b0, plen}) begin
        packed_bytes[k*8 +: 8] = pre[k[1:0]];
      end else if (rel < {1'b0, clen}) begin
        packed_bytes[k*8 +: 8] = dat[rel[1:0]];
      end
    end
  end

  // queue write
  always_comb begin
    push.valid = accept && (in_ch.func == FUNC_ENCODE);
    if (unsupported) begin
      push.entry.data  = {{(MAX_BYTES*8-8){1'b0}}, SPACE_BYTE};
      push.entry.count = 4'd1;
    end else begin
      push.entry.data  = packed_bytes;
      push.entry.count = {1'b0, plen} + {1'b0, clen};
    end
  end

  // designation updates, in request order
  always_comb begin
    left_set_nxt  = left_set_r;
    right_set_nxt = right_set_r;
    if (accept) begin
      if (in_ch.func == FUNC_REINIT) begin
        left_set_nxt  = start_mode_r ? ASCII_SET : SET_NONE;
        right_set_nxt = start_mode_r ? LATIN1_SET : SET_NONE;
      end else if (!unsupported && need_esc) begin
        if (right) begin
          right_set_nxt = set_id;
        end else begin
          left_set_nxt = set_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mode_r <= 1'b0;
      left_set_r   <= SET_NONE;
      right_set_r  <= SET_NONE;
    end else begin
      if (cfg_we) begin
        start_mode_r <= cfg_data;
      end
      left_set_r  <= left_set_nxt;
      right_set_r <= right_set_nxt;
    end
  end
endmodule

`default_nettype wire

// ----- sv/isoenc_queue.sv -----
`default_nettype none

module isoenc_queue #(
  parameter int Depth = isoenc_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire isoenc_pkg::isoenc_q_t  push,
  input  wire logic                   pop,
  output isoenc_pkg::isoenc_q_t       head,
  output isoenc_pkg::isoenc_qstat_t   qstat
);
  import isoenc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  isoenc_entry_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r,    cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign qstat.full  = cnt_r == CntW'(Depth);
  assign qstat.empty = cnt_r == '0;
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  assign head.valid  = !qstat.empty;
  assign head.entry  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end
endmodule

`default_nettype wire

// ----- sv/isoenc_back.sv -----
`default_nettype none

module isoenc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire isoenc_pkg::isoenc_q_t head,
  output logic                       pop,
  isoenc_out_if.source               out_ch
);
  import isoenc_pkg::*;

  logic [MAX_BYTES*8-1:0] cur_r, cur_nxt;
  logic [3:0]             rem_r, rem_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r,  out_byte_nxt;
  logic                   out_last_r,  out_last_nxt;
  logic                   adv;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  // output register can take a new byte
  assign adv = !out_valid_r || out_ch.ready;

  // one byte a cycle while adv, next entry on the last byte or when idle
  always_comb begin
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    if (adv) begin
      if (rem_r != 4'd0) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = cur_r[7:0];
        out_last_nxt  = rem_r == 4'd1;
        cur_nxt       = cur_r >> 8;
        rem_nxt       = rem_r - 4'd1;
        if (rem_r == 4'd1 && head.valid) begin
          pop     = 1'b1;
          cur_nxt = head.entry.data;
          rem_nxt = head.entry.count;
        end
      end else begin
        out_valid_nxt = 1'b0;
        if (head.valid) begin
          pop     = 1'b1;
          cur_nxt = head.entry.data;
          rem_nxt = head.entry.count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end
endmodule

`default_nettype wire

// ----- tb/isoenc_tb_pkg.sv -----
`timescale 1ns / 100ps

package isoenc_tb_pkg;

  // character set classes carried in set_class
  typedef enum logic [2:0] {
    CLS_94_SB       = 3'd0,
    CLS_94_MB       = 3'd1,
    CLS_96_SB       = 3'd2,
    CLS_96_MB       = 3'd3,
    CLS_UNSUPPORTED = 3'd4
  } set_class_e;

  // one expected output byte
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

endpackage

// ----- tb/isoenc_byte_compare.sv -----
`timescale 1ns / 100ps

module isoenc_byte_compare
  import isoenc_pkg::*;
  import isoenc_tb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic  cfg_data,
  isoenc_in_if  in_mon,
  isoenc_out_if out_mon,
  output int    fail_count,
  output int    pending,
  output int    bytes_checked,
  output int    escapes_predicted
);

  // predicted encoder state
  logic       mode_reg;
  logic [8:0] left_desig;
  logic [8:0] right_desig;

  // bytes still owed by the encoder, oldest first
  enc_byte_t  owed_bytes [$];
  enc_byte_t  want;

  int mismatches  = 0;
  int backlog     = 0;
  int byte_total  = 0;
  int esc_total   = 0;

  assign fail_count        = mismatches;
  assign pending           = backlog;
  assign bytes_checked     = byte_total;
  assign escapes_predicted = esc_total;

  function automatic void owe_byte(input logic [7:0] value, input logic last_flag);
    enc_byte_t entry;
    entry.value = value;
    entry.last  = last_flag;
    owed_bytes.push_back(entry);
  endfunction

  // expected output of one accepted request
  function automatic void predict_request(
    input logic       func,
    input logic [2:0] cls,
    input logic [6:0] fin,
    input logic [2:0] len_in,
    input logic [7:0] b0,
    input logic [7:0] b1,
    input logic [7:0] b2,
    input logic [7:0] b3
  );
    logic [7:0] code [4];
    logic [8:0] wanted;
    logic       is_multi;
    logic       is_right;
    int         nbytes;
    code[0] = b0;
    code[1] = b1;
    code[2] = b2;
    code[3] = b3;

    // reinitialize reloads both halves from the mode, no output
    if (func == FUNC_REINIT) begin
      left_desig  = mode_reg ? ASCII_SET : SET_NONE;
      right_desig = mode_reg ? LATIN1_SET : SET_NONE;
      return;
    end

    // unsupported and unknown classes give one space
    if (cls >= CLS_UNSUPPORTED) begin
      owe_byte(SPACE_BYTE, 1'b1);
      return;
    end

    // length clamped to 1..4
    if (len_in == 3'd0) nbytes = 1;
    else if (len_in > 3'd4) nbytes = 4;
    else nbytes = int'(len_in);

    is_multi = cls[0];
    is_right = cls[1];
    wanted   = {1'b1, is_multi, fin};

    // designation escape when the half changes set
    if (wanted != (is_right ? right_desig : left_desig)) begin
      esc_total++;
      owe_byte(ESC_BYTE, 1'b0);
      if (is_multi) owe_byte(MB_MARK, 1'b0);
      owe_byte(is_right ? SB96_MARK : SB94_MARK, 1'b0);
      owe_byte({1'b0, fin}, 1'b0);
      if (is_right) right_desig = wanted;
      else left_desig = wanted;
    end

    // code bytes, high bit forced for 96 sets
    for (int i = 0; i < nbytes; i++) begin
      owe_byte(is_right ? (code[i] | HIGH_BIT) : code[i], i == nbytes - 1);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_reg    = 1'b0;
      left_desig  = SET_NONE;
      right_desig = SET_NONE;
      owed_bytes.delete();
    end else begin
      // check an output request against the oldest owed byte
      if (out_mon.valid && out_mon.ready) begin
        if (owed_bytes.size() == 0) begin
          $error("out_byte unexpected: nothing owed, actual %02h last %0b",
                 out_mon.out_byte, out_mon.last);
          mismatches++;
        end else begin
          want = owed_bytes.pop_front();
          byte_total++;
          if (out_mon.out_byte !== want.value) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.value, out_mon.out_byte);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_mon.last);
            mismatches++;
          end
        end
      end

      // predict an accepted input request
      if (in_mon.valid && in_mon.ready) begin
        predict_request(in_mon.func, in_mon.set_class, in_mon.final_byte,
                        in_mon.char_len, in_mon.code_byte0, in_mon.code_byte1,
                        in_mon.code_byte2, in_mon.code_byte3);
      end

      // mode register, sampled only by later reinitialize requests
      if (cfg_we) mode_reg = cfg_data;
    end
    backlog = owed_bytes.size();
  end

endmodule

// ----- tb/tb_iso2022_escape_encoder.sv -----
`timescale 1ns / 100ps

module tb_iso2022_escape_encoder;
  import isoenc_pkg::*;
  import isoenc_tb_pkg::*;

  localparam int          RESET_CYCLES    = 12;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          LONG_HOLD       = 150;
  localparam int          PHASES          = 4;
  localparam int          ITEMS_PER_PHASE = 48;
  localparam int unsigned CYCLE_LIMIT     = 300000;

  // final bytes reused often so that designations repeat
  localparam logic [6:0] FINAL_POOL [6] = '{7'h42, 7'h41, 7'h4A, 7'h40, 7'h30, 7'h7E};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;

  isoenc_in_if  in_ch ();
  isoenc_out_if out_ch ();

  int fail_count;
  int pending;
  int bytes_checked;
  int escapes_predicted;

  // idling controls shared with the receiver
  logic src_idle      = 1'b1;
  logic sink_idle     = 1'b1;
  int   hold_requests = 0;
  int   holds_served  = 0;
  int   stall_left    = 0;

  int          n_sent   = 0;
  int          n_reinit = 0;
  int unsigned cycle_count = 0;

  iso2022_escape_encoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  isoenc_byte_compare u_compare (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .fail_count        (fail_count),
    .pending           (pending),
    .bytes_checked     (bytes_checked),
    .escapes_predicted (escapes_predicted)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls plus requested long holds
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        stall_left   = LONG_HOLD - 1;
        out_ch.ready = 1'b0;
      end else if (sink_idle) begin
        stall_left = idle_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready = 1'b0;
        end else begin
          out_ch.ready = 1'b1;
        end
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(
    input logic       func,
    input logic [2:0] cls,
    input logic [6:0] fin,
    input logic [2:0] len,
    input logic [7:0] b0,
    input logic [7:0] b1,
    input logic [7:0] b2,
    input logic [7:0] b3
  );
    int gap;
    gap = src_idle ? idle_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func       = func;
    in_ch.set_class  = cls;
    in_ch.final_byte = fin;
    in_ch.char_len   = len;
    in_ch.code_byte0 = b0;
    in_ch.code_byte1 = b1;
    in_ch.code_byte2 = b2;
    in_ch.code_byte3 = b3;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    if (func == FUNC_REINIT) n_reinit++;
  endtask

  task automatic reinit_request();
    send_request(FUNC_REINIT, 3'($urandom), 7'($urandom), 3'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // mode write once the encoder has drained
  task automatic write_mode(input logic value);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data = value;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // mostly well-formed characters, some reinitialize and noise
  task automatic random_request();
    int         r;
    logic [2:0] cls;
    logic [6:0] fin;
    logic [7:0] mask;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      reinit_request();
    end else if (r < 16) begin
      send_request(FUNC_ENCODE, 3'($urandom), 7'($urandom), 3'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      cls  = ($urandom_range(0, 19) == 0) ? CLS_UNSUPPORTED : 3'($urandom_range(0, 3));
      fin  = ($urandom_range(0, 9) < 7) ? FINAL_POOL[$urandom_range(0, 5)]
                                        : 7'($urandom_range(48, 126));
      mask = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'h7F;
      send_request(FUNC_ENCODE, cls, fin, 3'($urandom_range(1, 4)),
                   8'($urandom) & mask, 8'($urandom) & mask,
                   8'($urandom) & mask, 8'($urandom) & mask);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_ENCODE;
    in_ch.set_class  = CLS_94_SB;
    in_ch.final_byte = '0;
    in_ch.char_len   = '0;
    in_ch.code_byte0 = '0;
    in_ch.code_byte1 = '0;
    in_ch.code_byte2 = '0;
    in_ch.code_byte3 = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed: both halves undesignated after reset
    send_request(FUNC_ENCODE, CLS_94_SB, ASCII_SET[6:0], 3'd1, 8'h00, 8'h00, 8'h00, 8'h00);
    // high bit kept in a 94 set, no new escape
    send_request(FUNC_ENCODE, CLS_94_SB, ASCII_SET[6:0], 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_ENCODE, CLS_94_MB, ASCII_SET[6:0], 3'd2, 8'h30, 8'h21, 8'h00, 8'h00);
    // zero length and final byte below range
    send_request(FUNC_ENCODE, CLS_94_SB, 7'h00, 3'd0, 8'h7F, 8'hAA, 8'hAA, 8'hAA);
    // over-long length and final byte above range
    send_request(FUNC_ENCODE, CLS_94_SB, 7'h7F, 3'd7, 8'h01, 8'h02, 8'h03, 8'h04);
    send_request(FUNC_ENCODE, CLS_96_SB, LATIN1_SET[6:0], 3'd1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_ENCODE, CLS_96_SB, LATIN1_SET[6:0], 3'd1, 8'h7F, 8'h00, 8'h00, 8'h00);
    // longest output: multi byte escape plus four bytes
    send_request(FUNC_ENCODE, CLS_96_MB, LATIN1_SET[6:0], 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(FUNC_ENCODE, CLS_96_MB, LATIN1_SET[6:0], 3'd5, 8'h55, 8'h2A, 8'h00, 8'h80);
    // unsupported and unknown classes
    send_request(FUNC_ENCODE, CLS_UNSUPPORTED, ASCII_SET[6:0], 3'd3,
                 8'h41, 8'h42, 8'h43, 8'h44);
    for (int k = int'(CLS_UNSUPPORTED) + 1; k < 8; k++) begin
      send_request(FUNC_ENCODE, 3'(k), 7'h7F, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    end
    // reinitialize in mode zero clears both halves again
    send_request(FUNC_REINIT, CLS_94_SB, ASCII_SET[6:0], 3'd1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_ENCODE, CLS_96_SB, LATIN1_SET[6:0], 3'd1, 8'h20, 8'h00, 8'h00, 8'h00);

    // compound text start: ASCII left, Latin-1 right
    write_mode(1'b1);
    send_request(FUNC_ENCODE, CLS_94_SB, ASCII_SET[6:0], 3'd1, 8'h41, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_REINIT, 3'h7, 7'h7F, 3'h7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(FUNC_ENCODE, CLS_94_SB, ASCII_SET[6:0], 3'd1, 8'h41, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_ENCODE, CLS_96_SB, LATIN1_SET[6:0], 3'd1, 8'h60, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_ENCODE, CLS_96_MB, LATIN1_SET[6:0], 3'd6, 8'h11, 8'h22, 8'h33, 8'h44);
    send_request(FUNC_ENCODE, CLS_94_MB, ASCII_SET[6:0], 3'd1, 8'h21, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_REINIT, CLS_94_SB, 7'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(FUNC_ENCODE, CLS_94_SB, ASCII_SET[6:0], 3'd2, 8'h7E, 8'h80, 8'h00, 8'h00);

    // random phases alternating the start mode
    for (int p = 0; p < PHASES; p++) begin
      write_mode(1'(p % 2));
      src_idle  = (p != 1);
      sink_idle = (p != 1);
      reinit_request();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // long receiver hold while requests keep coming back to back
        if (p == 2 && k == 10) begin
          hold_requests++;
          src_idle = 1'b0;
        end
        if (p == 2 && k == 35) src_idle = 1'b1;
        random_request();
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES * 4) @(negedge clk);

    $display("sent %0d requests (%0d reinitialize) over %0d mode phases",
             n_sent, n_reinit, PHASES + 1);
    $display("checked %0d output bytes, %0d designation escapes expected",
             bytes_checked, escapes_predicted);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
